[hdl/sfpv_pkg.sv]
// Shared types, constants and a helper function for the stick frame to polar velocity block.
// No dependencies.
package sfpv_pkg;

  localparam int unsigned StrokeDef      = 660;
  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned TabLen         = 24;
  localparam int signed   PiQ13          = 25736;
  localparam int signed   SpeedLimit     = 4194048;

  localparam logic [2:0] REG_STICK_CENTER = 3'd0;
  localparam logic [2:0] REG_DEAD_ZONE    = 3'd1;
  localparam logic [2:0] REG_MAX_RPM      = 3'd2;
  localparam logic [2:0] REG_DZ_VALUE     = 3'd3;
  localparam logic [2:0] REG_RATE_UP      = 3'd4;
  localparam logic [2:0] REG_RATE_MID     = 3'd5;
  localparam logic [2:0] REG_RATE_DOWN    = 3'd6;

  localparam logic [1:0] SW_UP   = 2'd1;
  localparam logic [1:0] SW_DOWN = 2'd2;
  localparam logic [1:0] SW_MID  = 2'd3;

  typedef struct packed {
    logic [10:0] c0;
    logic [10:0] c1;
    logic [10:0] c2;
    logic [10:0] c3;
    logic [1:0]  s1;
    logic [1:0]  s2;
    logic [8:0]  gear;
  } item_t;

  function automatic logic signed [15:0] atan_lut(input logic [4:0] i);
    logic signed [15:0] r;
    r = 16'sd0;
    case (i)
      5'd0: r = 16'sd6434;
      5'd1: r = 16'sd3798;
      5'd2: r = 16'sd2007;
      5'd3: r = 16'sd1019;
      5'd4: r = 16'sd511;
      5'd5: r = 16'sd256;
      5'd6: r = 16'sd128;
      5'd7: r = 16'sd64;
      5'd8: r = 16'sd32;
      5'd9: r = 16'sd16;
      5'd10: r = 16'sd8;
      5'd11: r = 16'sd4;
      5'd12: r = 16'sd2;
      5'd13: r = 16'sd1;
      default: r = 16'sd0;
    endcase
    return r;
  endfunction

endpackage

[hdl/sfpv_front.sv]
// Front end: unpacks frames, fixes zero switches, attaches and updates the gear rate.
// Depends on sfpv_pkg.
module sfpv_front import sfpv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [47:0] frame_bits_i,
  input  logic [8:0]  rate_up_i,
  input  logic [8:0]  rate_mid_i,
  input  logic [8:0]  rate_down_i,
  output logic        q_valid_o,
  input  logic        q_full_i,
  output item_t       q_item_o
);

  logic [8:0] gear_q, gear_d;
  logic [1:0] s1, s2;
  logic [8:0] nr;
  logic       acc;

  assign in_stall = q_full_i;
  assign acc      = in_valid & ~q_full_i;
  assign s1 = (frame_bits_i[45:44] == 2'd0) ? SW_MID : frame_bits_i[45:44];
  assign s2 = (frame_bits_i[47:46] == 2'd0) ? SW_MID : frame_bits_i[47:46];

  always_comb begin
    case (s2)
      SW_UP:   nr = rate_up_i;
      SW_DOWN: nr = rate_down_i;
      default: nr = rate_mid_i;
    endcase
    gear_d = (nr > 9'd256) ? 9'd256 : nr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gear_q <= 9'd256;
    end else if (acc) begin
      gear_q <= gear_d;
    end
  end

  assign q_valid_o = acc;
  assign q_item_o  = '{c0: frame_bits_i[10:0], c1: frame_bits_i[21:11],
                       c2: frame_bits_i[32:22], c3: frame_bits_i[43:33],
                       s1: s1, s2: s2, gear: gear_q};

endmodule

[hdl/sfpv_queue.sv]
// Two-entry queue between front and back ends.
// Depends on sfpv_pkg.
module sfpv_queue import sfpv_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_i,
  input  item_t wdata_i,
  output logic  full_o,
  output logic  empty_o,
  input  logic  rd_i,
  output item_t rdata_o
);

  item_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_i) wp_q <= ~wp_q;
      if (rd_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr_i} - {1'b0, rd_i};
    end
  end

endmodule

[hdl/sfpv_back.sv]
// Back end: stick map, speed scaling, iterative square root and CORDIC heading.
// Depends on sfpv_pkg.
module sfpv_back import sfpv_pkg::*; #(
  parameter int unsigned STROKE       = StrokeDef,
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  item_t              q_item_i,
  output logic               q_rd_o,
  input  logic [10:0]        stick_center_i,
  input  logic [9:0]         dead_zone_i,
  input  logic [13:0]        max_rpm_i,
  input  logic [14:0]        dz_value_i,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [10:0]        chan_zero_o,
  output logic [10:0]        chan_one_o,
  output logic [10:0]        chan_two_o,
  output logic [10:0]        chan_three_o,
  output logic [1:0]         switch_one_o,
  output logic [1:0]         switch_two_o,
  output logic signed [22:0] forward_speed_o,
  output logic signed [22:0] side_speed_o,
  output logic [22:0]        speed_magnitude_o,
  output logic signed [15:0] heading_angle_o,
  output logic signed [14:0] spin_rate_o
);

  localparam int unsigned Steps    = (CORDIC_STEPS > TabLen) ? TabLen : CORDIC_STEPS;
  localparam int unsigned DivShift = 25 + $clog2(STROKE);
  localparam logic [25:0] Recip    =
    26'(((64'd1 << DivShift) + 64'(STROKE) - 64'd1) / 64'(STROKE));

  typedef enum logic [7:0] {
    ST_IDLE = 8'b00000001,
    ST_MAP  = 8'b00000010,
    ST_DIV  = 8'b00000100,
    ST_CLMP = 8'b00001000,
    ST_MUL  = 8'b00010000,
    ST_SQRT = 8'b00100000,
    ST_CORD = 8'b01000000,
    ST_OUT  = 8'b10000000
  } state_e;

  state_e state_q;
  item_t  it_q;
  logic [1:0]  ch_q;
  logic [24:0] prod_q;
  logic [24:0] quo_q;
  logic        neg_q;
  logic signed [14:0] rpm_q [3];
  logic signed [22:0] fwd_q, side_q;
  logic [45:0] sv_q;
  logic [45:0] sres_q, sbit_q;
  logic signed [33:0] cx_q, cy_q;
  logic signed [16:0] cz_q;
  logic [4:0]  ci_q;

  logic [10:0] ch;
  logic signed [11:0] diff;
  logic [10:0] adiff;
  logic        in_dz;
  logic [50:0] qprod;
  logic [13:0] rmag;
  logic signed [14:0] rnew;
  logic signed [23:0] fm, sm;
  logic signed [22:0] fs, ss;
  logic [45:0] sumsq, stry;
  logic signed [33:0] xs, ys;
  logic signed [16:0] zw;

  always_comb begin
    case (ch_q)
      2'd0:    ch = it_q.c3;
      2'd1:    ch = it_q.c2;
      default: ch = it_q.c0;
    endcase
  end
  assign diff  = $signed({1'b0, ch}) - $signed({1'b0, stick_center_i});
  assign adiff = diff[11] ? 11'(-diff) : diff[10:0];
  assign in_dz = (adiff <= {1'b0, dead_zone_i});
  assign qprod = 51'(prod_q) * 51'(Recip);
  assign rmag  = (quo_q > 25'(max_rpm_i)) ? max_rpm_i : quo_q[13:0];
  assign rnew  = neg_q ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
  assign fm = -(24'(rpm_q[0]) * $signed({1'b0, it_q.gear}));
  assign sm = 24'(rpm_q[1]) * $signed({1'b0, it_q.gear});
  assign fs = (fm > 24'(SpeedLimit)) ? 23'(SpeedLimit) :
              (fm < -24'(SpeedLimit)) ? -23'(SpeedLimit) : fm[22:0];
  assign ss = (sm > 24'(SpeedLimit)) ? 23'(SpeedLimit) :
              (sm < -24'(SpeedLimit)) ? -23'(SpeedLimit) : sm[22:0];
  assign sumsq = 46'(fwd_q * fwd_q) + 46'(side_q * side_q);
  assign stry  = sres_q + sbit_q;
  assign xs = cx_q >>> ci_q;
  assign ys = cy_q >>> ci_q;
  assign zw = (cz_q > 17'(PiQ13)) ? cz_q - 17'(2 * PiQ13) :
              (cz_q < -17'(PiQ13)) ? cz_q + 17'(2 * PiQ13) : cz_q;

  assign q_rd_o    = (state_q == ST_IDLE) & ~q_empty_i;
  assign out_valid = (state_q == ST_OUT);

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (!q_empty_i) it_q <= q_item_i;
      ST_MAP: begin
        if (in_dz) begin
          rpm_q[ch_q] <= $signed(dz_value_i);
        end else begin
          prod_q <= 25'(adiff) * 25'(max_rpm_i);
          neg_q  <= diff[11];
        end
      end
      ST_DIV:  quo_q <= 25'(qprod >> DivShift);
      ST_CLMP: rpm_q[ch_q] <= rnew;
      ST_MUL: begin
        if (ch_q == 2'd0) begin
          sv_q   <= sumsq;
          sres_q <= '0;
          sbit_q <= 46'd1 << 44;
        end else begin
          fwd_q       <= fs;
          side_q      <= ss;
          spin_rate_o <= rpm_q[2] / 15'sd2;
        end
      end
      ST_SQRT: begin
        if (sbit_q == 46'd0) begin
          speed_magnitude_o <= sres_q[22:0];
          if (fwd_q < 0) begin
            cx_q <= -(34'(fwd_q) <<< 8);
            cy_q <= -(34'(side_q) <<< 8);
            cz_q <= (side_q >= 0) ? 17'(PiQ13) : -17'(PiQ13);
          end else begin
            cx_q <= 34'(fwd_q) <<< 8;
            cy_q <= 34'(side_q) <<< 8;
            cz_q <= '0;
          end
        end else begin
          if (sv_q >= stry) begin
            sv_q   <= sv_q - stry;
            sres_q <= (sres_q >> 1) + sbit_q;
          end else begin
            sres_q <= sres_q >> 1;
          end
          sbit_q <= sbit_q >> 2;
        end
      end
      ST_CORD: begin
        if (cy_q > 0) begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + atan_lut(ci_q);
        end else begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - atan_lut(ci_q);
        end
        if (ci_q == 5'(Steps)) begin
          heading_angle_o <= (speed_magnitude_o == 23'd0) ? 16'sd0 : zw[15:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ch_q    <= 2'd0;
      ci_q    <= 5'd0;
    end else begin
      case (state_q)
        ST_IDLE: if (!q_empty_i) begin
          state_q <= ST_MAP;
          ch_q    <= 2'd0;
        end
        ST_MAP: begin
          if (in_dz) begin
            if (ch_q == 2'd2) state_q <= ST_MUL;
            ch_q <= ch_q + 2'd1;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: state_q <= ST_CLMP;
        ST_CLMP: begin
          state_q <= (ch_q == 2'd2) ? ST_MUL : ST_MAP;
          ch_q    <= ch_q + 2'd1;
        end
        ST_MUL: begin
          if (ch_q == 2'd0) state_q <= ST_SQRT;
          ch_q <= 2'd0;
        end
        ST_SQRT: if (sbit_q == 46'd0) begin
          state_q <= ST_CORD;
          ci_q    <= 5'd0;
        end
        ST_CORD: begin
          if (ci_q == 5'(Steps)) state_q <= ST_OUT;
          ci_q <= ci_q + 5'd1;
        end
        ST_OUT: if (!out_stall) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign chan_zero_o  = it_q.c0;
  assign chan_one_o   = it_q.c1;
  assign chan_two_o   = it_q.c2;
  assign chan_three_o = it_q.c3;
  assign switch_one_o = it_q.s1;
  assign switch_two_o = it_q.s2;
  assign forward_speed_o = fwd_q;
  assign side_speed_o    = side_q;

endmodule

[hdl/stick_frame_to_polar_velocity.sv]
// A frame passes, with an idle back end, through the stick maps (the dead zone value inside
// the dead zone, else a reciprocal multiply and clamp), speed scaling, the iterative square
// root and the CORDIC loop, in that order.
// Flow: the back end works on one frame at a time; the queue holds two more, a stalled result holds.
// Reset: asynchronous active low; control and configuration registers return to reset values, gear rate to full.
// Depends on sfpv_pkg, sfpv_front, sfpv_queue, sfpv_back.
module stick_frame_to_polar_velocity import sfpv_pkg::*; #(
  parameter int unsigned STROKE       = StrokeDef,
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [47:0]        frame_bits_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [14:0]        cfg_data_i,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [10:0]        chan_zero_o,
  output logic [10:0]        chan_one_o,
  output logic [10:0]        chan_two_o,
  output logic [10:0]        chan_three_o,
  output logic [1:0]         switch_one_o,
  output logic [1:0]         switch_two_o,
  output logic signed [22:0] forward_speed_o,
  output logic signed [22:0] side_speed_o,
  output logic [22:0]        speed_magnitude_o,
  output logic signed [15:0] heading_angle_o,
  output logic signed [14:0] spin_rate_o
);

  logic [10:0] center_q;
  logic [9:0]  dz_q;
  logic [13:0] max_q;
  logic [14:0] dzv_q;
  logic [8:0]  up_q, mid_q, down_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= 11'd1024;
      dz_q     <= 10'd10;
      max_q    <= 14'd8000;
      dzv_q    <= '0;
      up_q     <= 9'd256;
      mid_q    <= 9'd128;
      down_q   <= 9'd51;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STICK_CENTER: center_q <= cfg_data_i[10:0];
        REG_DEAD_ZONE:    dz_q     <= cfg_data_i[9:0];
        REG_MAX_RPM:      max_q    <= cfg_data_i[13:0];
        REG_DZ_VALUE:     dzv_q    <= cfg_data_i;
        REG_RATE_UP:      up_q     <= cfg_data_i[8:0];
        REG_RATE_MID:     mid_q    <= cfg_data_i[8:0];
        REG_RATE_DOWN:    down_q   <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  logic  q_wr, q_full, q_empty, q_rd;
  item_t q_wdata, q_rdata;

  sfpv_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .frame_bits_i,
    .rate_up_i(up_q), .rate_mid_i(mid_q), .rate_down_i(down_q),
    .q_valid_o(q_wr), .q_full_i(q_full), .q_item_o(q_wdata)
  );

  sfpv_queue u_queue (
    .clk_i, .rst_ni, .wr_i(q_wr), .wdata_i(q_wdata), .full_o(q_full),
    .empty_o(q_empty), .rd_i(q_rd), .rdata_o(q_rdata)
  );

  sfpv_back #(.STROKE(STROKE), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .q_item_i(q_rdata), .q_rd_o(q_rd),
    .stick_center_i(center_q), .dead_zone_i(dz_q), .max_rpm_i(max_q),
    .dz_value_i(dzv_q), .out_valid, .out_stall,
    .chan_zero_o, .chan_one_o, .chan_two_o, .chan_three_o,
    .switch_one_o, .switch_two_o, .forward_speed_o, .side_speed_o,
    .speed_magnitude_o, .heading_angle_o, .spin_rate_o
  );

`ifndef ASSERT_OFF
  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_wr) else $error("queue overflow");
  a_no_read_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_empty |-> !q_rd) else $error("queue underflow");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
`endif

endmodule

[dv/sfpv_checker.sv]
`timescale 1ns / 100ps
// Checker for stick_frame_to_polar_velocity: watches both channels and the register port,
// predicts every result and compares it field by field. Depends on sfpv_pkg.
module sfpv_checker import sfpv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [47:0]        frame_bits_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [14:0]        cfg_data_i,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [10:0]        chan_zero_o,
  input  logic [10:0]        chan_one_o,
  input  logic [10:0]        chan_two_o,
  input  logic [10:0]        chan_three_o,
  input  logic [1:0]         switch_one_o,
  input  logic [1:0]         switch_two_o,
  input  logic signed [22:0] forward_speed_o,
  input  logic signed [22:0] side_speed_o,
  input  logic [22:0]        speed_magnitude_o,
  input  logic signed [15:0] heading_angle_o,
  input  logic signed [14:0] spin_rate_o,
  output int                 pending_o,
  output int                 fails_o
);

  typedef struct {
    logic [10:0]        c0, c1, c2, c3;
    logic [1:0]         s1, s2;
    logic signed [22:0] fwd, side;
    logic [22:0]        mag;
    logic signed [15:0] ang;
    logic signed [14:0] spin;
  } velocity_t;

  localparam int Stroke = 660;
  localparam int Steps  = 16;

  logic [10:0] center_q;
  logic [9:0]  dz_q;
  logic [13:0] max_q;
  logic [14:0] dzv_q;
  logic [8:0]  rate_up_q, rate_mid_q, rate_down_q, gear_q;
  velocity_t   expected_q[$];
  int          fails;

  assign pending_o = expected_q.size();
  assign fails_o   = fails;

  function automatic int stick_to_rpm(input logic [10:0] ch);
    int diff, ad, lim, r;
    diff = int'(ch) - int'(center_q);
    ad   = diff < 0 ? -diff : diff;
    lim  = int'(max_q);
    if (ad <= int'(dz_q)) return int'($signed(dzv_q));
    r = (diff * lim) / Stroke;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic int clamp_speed(input int v);
    if (v > SpeedLimit) return SpeedLimit;
    if (v < -SpeedLimit) return -SpeedLimit;
    return v;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res, bit_w;
    res   = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w >>= 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v   = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  function automatic int heading_of(input int yi, input int xi);
    int     arc[14] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16, 8, 4, 2, 1};
    longint x, y, xs, ys;
    int     z, a;
    x = longint'(xi) * 256;
    y = longint'(yi) * 256;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? PiQ13 : -PiQ13;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < Steps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      a  = i < 14 ? arc[i] : 0;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + a;
      end else begin
        x = x - ys; y = y + xs; z = z - a;
      end
    end
    if (z > PiQ13) z = z - 2 * PiQ13;
    else if (z < -PiQ13) z = z + 2 * PiQ13;
    return z;
  endfunction

  function automatic velocity_t frame_to_velocity(input logic [47:0] f);
    velocity_t v;
    int        fwd, side;
    v.c0 = f[10:0];
    v.c1 = f[21:11];
    v.c2 = f[32:22];
    v.c3 = f[43:33];
    v.s1 = f[45:44] == 2'd0 ? SW_MID : f[45:44];
    v.s2 = f[47:46] == 2'd0 ? SW_MID : f[47:46];
    fwd  = clamp_speed(-stick_to_rpm(v.c3) * int'(gear_q));
    side = clamp_speed(stick_to_rpm(v.c2) * int'(gear_q));
    v.fwd  = 23'(fwd);
    v.side = 23'(side);
    v.spin = 15'(stick_to_rpm(v.c0) / 2);
    v.mag  = 23'(root_floor(longint'(fwd) * fwd + longint'(side) * side));
    v.ang  = v.mag != 0 ? 16'(heading_of(side, fwd)) : 16'sd0;
    return v;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    velocity_t e;
    logic [8:0] nr;
    if (!rst_ni) begin
      center_q    <= 11'd1024;
      dz_q        <= 10'd10;
      max_q       <= 14'd8000;
      dzv_q       <= '0;
      rate_up_q   <= 9'd256;
      rate_mid_q  <= 9'd128;
      rate_down_q <= 9'd51;
      gear_q      <= 9'd256;
      expected_q.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_STICK_CENTER: center_q    <= cfg_data_i[10:0];
          REG_DEAD_ZONE:    dz_q        <= cfg_data_i[9:0];
          REG_MAX_RPM:      max_q       <= cfg_data_i[13:0];
          REG_DZ_VALUE:     dzv_q       <= cfg_data_i;
          REG_RATE_UP:      rate_up_q   <= cfg_data_i[8:0];
          REG_RATE_MID:     rate_mid_q  <= cfg_data_i[8:0];
          REG_RATE_DOWN:    rate_down_q <= cfg_data_i[8:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        e = frame_to_velocity(frame_bits_i);
        expected_q.push_back(e);
        nr = e.s2 == SW_UP ? rate_up_q : (e.s2 == SW_DOWN ? rate_down_q : rate_mid_q);
        gear_q <= nr > 9'd256 ? 9'd256 : nr;
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t transfer on the result channel with nothing expected", $time);
          fails++;
        end else begin
          e = expected_q.pop_front();
          if (chan_zero_o != e.c0) report("chan_zero", chan_zero_o, e.c0);
          if (chan_one_o != e.c1) report("chan_one", chan_one_o, e.c1);
          if (chan_two_o != e.c2) report("chan_two", chan_two_o, e.c2);
          if (chan_three_o != e.c3) report("chan_three", chan_three_o, e.c3);
          if (switch_one_o != e.s1) report("switch_one", switch_one_o, e.s1);
          if (switch_two_o != e.s2) report("switch_two", switch_two_o, e.s2);
          if (forward_speed_o != e.fwd) report("forward_speed", forward_speed_o, e.fwd);
          if (side_speed_o != e.side) report("side_speed", side_speed_o, e.side);
          if (speed_magnitude_o != e.mag) report("speed_magnitude", speed_magnitude_o, e.mag);
          if (heading_angle_o != e.ang) report("heading_angle", heading_angle_o, e.ang);
          if (spin_rate_o != e.spin) report("spin_rate", spin_rate_o, e.spin);
        end
      end
    end
  end

endmodule

[dv/tb_stick_frame_to_polar_velocity.sv]
`timescale 1ns / 100ps
// Testbench top for stick_frame_to_polar_velocity: drives frames, register writes and
// result stalls, and gives the verdict. Depends on sfpv_pkg, sfpv_checker and the block.
module tb_stick_frame_to_polar_velocity;
  import sfpv_pkg::*;

  localparam int IdleLimit = 20000;
  localparam int Settle    = 150;

  logic               clk_i, rst_ni;
  logic               in_valid, in_stall, out_valid, out_stall;
  logic [47:0]        frame_bits_i;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [14:0]        cfg_data_i;
  logic [10:0]        chan_zero_o, chan_one_o, chan_two_o, chan_three_o;
  logic [1:0]         switch_one_o, switch_two_o;
  logic signed [22:0] forward_speed_o, side_speed_o;
  logic [22:0]        speed_magnitude_o;
  logic signed [15:0] heading_angle_o;
  logic signed [14:0] spin_rate_o;
  int                 pending, fails, frames_sent, setups;
  logic               frame_taken;
  int                 gap_mode, stall_mode;
  logic [10:0]        center_now;

  stick_frame_to_polar_velocity dut (.*);
  sfpv_checker u_checker (.*, .pending_o(pending), .fails_o(fails));

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) frame_taken <= in_valid && !in_stall;

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
      if (idle >= IdleLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic int pick_gap(input int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  initial begin
    out_stall  = 1'b0;
    stall_mode = 0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
      out_stall = stall_mode == 0 ? 1'b0 : pick_gap(1) != 0;
      if (stall_mode == 2 && $urandom_range(0, 29) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(20, 60)) @(negedge clk_i);
      end
    end
  end

  task automatic send_frame(input logic [47:0] f);
    in_valid     = 1'b1;
    frame_bits_i = f;
    do @(negedge clk_i); while (!frame_taken);
    frames_sent++;
    in_valid = 1'b0;
    repeat (pick_gap(gap_mode)) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [14:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    if (idx == REG_STICK_CENTER) center_now = data[10:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic drain;
    while (pending != 0) @(negedge clk_i);
    repeat (Settle) @(negedge clk_i);
  endtask

  function automatic logic [10:0] pick_stick;
    int r, v;
    r = $urandom_range(0, 3);
    case (r)
      0: v = $urandom_range(0, 2047);
      1: v = int'(center_now) + $urandom_range(0, 60) - 30;
      2: v = int'(center_now) + $urandom_range(0, 1600) - 800;
      default: v = $urandom_range(0, 1) ? 0 : 2047;
    endcase
    if (v < 0) v = 0;
    if (v > 2047) v = 2047;
    return 11'(v);
  endfunction

  function automatic logic [47:0] make_frame(input logic [10:0] c0, c1, c2, c3,
                                             input logic [1:0] s1, s2);
    return {s2, s1, c3, c2, c1, c0};
  endfunction

  task automatic random_frames(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_frame(48'({$urandom, $urandom}));
      else send_frame(make_frame(pick_stick(), 11'($urandom), pick_stick(), pick_stick(),
                                 2'($urandom), 2'($urandom)));
      if (i == n / 2 && setups == 1) while (pending != 0) @(negedge clk_i);
    end
  endtask

  task automatic setup(input logic [10:0] ctr, input logic [9:0] dz, input logic [13:0] mx,
                       input logic [14:0] dzv, input logic [8:0] up, mid, down);
    drain();
    write_reg(REG_STICK_CENTER, ctr);
    write_reg(REG_DEAD_ZONE, dz);
    write_reg(REG_MAX_RPM, mx);
    write_reg(REG_DZ_VALUE, dzv);
    write_reg(REG_RATE_UP, up);
    write_reg(REG_RATE_MID, mid);
    write_reg(REG_RATE_DOWN, down);
    write_reg(3'd7, 15'($urandom));
    setups++;
  endtask

  initial begin
    in_valid     = 1'b0;
    frame_bits_i = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_STICK_CENTER;
    cfg_data_i   = '0;
    frames_sent  = 0;
    setups       = 0;
    gap_mode     = 0;
    center_now   = 11'd1024;
    rst_ni       = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // rest, dead zone edges, full strokes, every switch code incl. zero
    send_frame(make_frame(1024, 1024, 1024, 1024, 2'd0, 2'd0));
    send_frame(make_frame(1034, 0, 1014, 1035, SW_UP, SW_UP));
    send_frame(make_frame(1013, 2047, 1035, 1013, SW_DOWN, SW_DOWN));
    send_frame(make_frame(2047, 1024, 2047, 2047, SW_MID, SW_MID));
    send_frame(make_frame(0, 1024, 0, 0, 2'd0, SW_UP));
    send_frame(make_frame(0, 1024, 2047, 0, SW_UP, SW_DOWN));
    send_frame(make_frame(2047, 1024, 0, 2047, SW_DOWN, 2'd0));
    send_frame(make_frame(1024, 1024, 1500, 1024, SW_MID, SW_UP));
    send_frame(make_frame(1024, 1024, 500, 1024, SW_MID, SW_UP));
    send_frame(make_frame(1024, 1024, 1024, 500, SW_MID, SW_UP));
    send_frame(make_frame(1684, 1024, 1024, 1684, SW_MID, SW_UP));
    send_frame('1);
    send_frame('0);
    gap_mode = 1;
    random_frames(180);

    setup(11'd1024, 10'd0, 14'd16383, 15'd0, 9'd511, 9'd257, 9'd0);
    random_frames(160);
    setup(11'd0, 10'd1023, 14'd0, 15'h3FFF, 9'd1, 9'd256, 9'd255);
    gap_mode = 0;
    random_frames(120);
    setup(11'd2047, 10'd1023, 14'd16383, 15'h4000, 9'd256, 9'd300, 9'd256);
    gap_mode = 1;
    random_frames(120);
    setup(11'd1024, 10'd5, 14'd16383, 15'h4001, 9'd256, 9'd256, 9'd256);
    random_frames(120);
    setup(11'd900, 10'd20, 14'd12000, 15'd200, 9'd200, 9'd100, 9'd30);
    random_frames(200);

    drain();
    $display("Sent %0d frames across %0d register setups plus reset values,", frames_sent,
             setups);
    $display("with random gaps and result stalls; %0d mismatches seen.", fails);
    if (fails == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

[stick_frame_to_polar_velocity.f]
hdl/sfpv_pkg.sv
hdl/sfpv_front.sv
hdl/sfpv_queue.sv
hdl/sfpv_back.sv
hdl/stick_frame_to_polar_velocity.sv
dv/sfpv_checker.sv
dv/tb_stick_frame_to_polar_velocity.sv
